>>> src/rsds_pkg.sv
// Radial stick dead-zone scaler: shared types and constants.
// No dependencies.
`default_nettype none
package rsds_pkg;
	localparam int unsigned MAX_MAG = 32767;
	localparam logic [0:0] REG_LEFT_DZ = 1'b0;
	localparam logic [0:0] REG_RIGHT_DZ = 1'b1;

	// item passed from the front part to the back part through the queue
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] dz;
	} rsds_item_t;

	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic dead;
	} rsds_res_t;
endpackage
`default_nettype wire

>>> src/rsds_front.sv
// Front part: accepts items, picks the dead zone, pushes into a small queue.
// Depends on rsds_pkg.
`default_nettype none
module rsds_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [15:0] in_x,
	input wire logic signed [15:0] in_y,
	input wire logic in_sel,
	input wire logic [14:0] left_dz,
	input wire logic [14:0] right_dz,
	output logic q_valid,
	input wire logic q_ready,
	output rsds_pkg::rsds_item_t q_item
);
	rsds_pkg::rsds_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;
	rsds_pkg::rsds_item_t item_in;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_comb begin
		item_in.x = in_x;
		item_in.y = in_y;
		item_in.dz = in_sel ? left_dz : right_dz;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("accept while full");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("pointer skew");
endmodule
`default_nettype wire

>>> src/rsds_back.sv
// Back part: pipelined magnitude, scale and rounding; stall-able with output register.
// Depends on rsds_pkg.
`default_nettype none
module rsds_back #(
	parameter int OUT_FRAC_BITS = 15
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire rsds_pkg::rsds_item_t q_item,
	output logic out_valid,
	input wire logic out_ready,
	output rsds_pkg::rsds_res_t out_res
);
	// Stages: s1 square sum, 16 sqrt stages (one result bit per stage),
	// two multiply stages, divide (16 restoring steps split 2 per stage), output.
	localparam int SQ = 16;  // sqrt stages
	localparam int QW = 16;  // quotient bits needed (2n+d)/(2d), at most 2^15
	localparam int DS = 8;   // divider stages
	localparam int STEPS = QW / DS;
	localparam int NS = 1 + SQ + 2 + DS + 1;
	localparam int NW = 64;

	logic adv;
	logic [NS-1:0] v_q;

	// shared stall: whole pipe moves when last stage can drain
	assign adv = !v_q[NS-1] || out_ready;
	assign q_ready = adv;
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS-2:0], q_valid};
	end

	// stage 1: abs and sum of squares (at most 2^31, fits 32 bits)
	logic signed [15:0] x_s1, y_s1;
	logic [14:0] dz_s1;
	logic [31:0] sum_s1;
	logic [16:0] ax, ay;
	assign ax = q_item.x[15] ? 17'(-$signed({q_item.x[15], q_item.x})) : {1'b0, q_item.x};
	assign ay = q_item.y[15] ? 17'(-$signed({q_item.y[15], q_item.y})) : {1'b0, q_item.y};
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= q_item.x;
			y_s1 <= q_item.y;
			dz_s1 <= q_item.dz;
			sum_s1 <= 32'(ax * ax) + 32'(ay * ay);
		end
	end

	// sqrt pipeline: restoring, one result bit per stage
	logic [33:0] rem_p [SQ+1];
	logic [16:0] rt_p [SQ+1];
	logic [32:0] val_p [SQ+1];
	logic signed [15:0] xp [SQ+1];
	logic signed [15:0] yp [SQ+1];
	logic [14:0] dzp [SQ+1];
	always_comb begin
		rem_p[0] = '0;
		rt_p[0] = '0;
		val_p[0] = {sum_s1, 1'b0};
		xp[0] = x_s1;
		yp[0] = y_s1;
		dzp[0] = dz_s1;
	end
	genvar g;
	generate
		for (g = 0; g < SQ + 1 - 1; g++) begin : g_sq
			logic [33:0] r_n, t_n;
			logic [32:0] v_n;
			always_comb begin
				r_n = {rem_p[g][31:0], val_p[g][32:31]};
				t_n = {15'd0, rt_p[g], 2'b01};
				v_n = {val_p[g][30:0], 2'b00};
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					if (r_n >= t_n) begin
						rem_p[g+1] <= r_n - t_n;
						rt_p[g+1] <= {rt_p[g][15:0], 1'b1};
					end else begin
						rem_p[g+1] <= r_n;
						rt_p[g+1] <= {rt_p[g][15:0], 1'b0};
					end
					val_p[g+1] <= v_n;
					xp[g+1] <= xp[g];
					yp[g+1] <= yp[g];
					dzp[g+1] <= dzp[g];
				end
			end
		end
	endgenerate
	// 32-bit sum: 16 bit pairs, all consumed by the sqrt stages
	logic [16:0] mag;
	assign mag = rt_p[SQ];

	// mul stage A: dead-zone test, num, den; d = mag*den
	logic [16:0] ax_a, ay_a;
	logic nx_a, ny_a, dead_a, zero_a;
	logic [14:0] num_a;
	logic [32:0] d_a;
	logic [14:0] num_c, den_c;
	logic [15:0] m_c;
	always_comb begin
		m_c = (mag > 17'(rsds_pkg::MAX_MAG)) ? 16'(rsds_pkg::MAX_MAG) : mag[15:0];
		num_c = 15'(m_c - {1'b0, dzp[SQ]});
		den_c = 15'(16'(rsds_pkg::MAX_MAG) - {1'b0, dzp[SQ]});
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dead_a <= mag <= {2'b0, dzp[SQ]};
			zero_a <= (num_c == '0) || (den_c == '0);
			num_a <= num_c;
			d_a <= 33'(mag * den_c);
			nx_a <= xp[SQ][15];
			ny_a <= yp[SQ][15];
			ax_a <= xp[SQ][15] ? 17'(-$signed({xp[SQ][15], xp[SQ]})) : {1'b0, xp[SQ]};
			ay_a <= yp[SQ][15] ? 17'(-$signed({yp[SQ][15], yp[SQ]})) : {1'b0, yp[SQ]};
		end
	end

	// mul stage B: n = a*num*2^F ; dividend 2n+d, divisor 2d
	logic [NW-1:0] nx_b, ny_b, dv_b;
	logic negx_b, negy_b, dead_b, zero_b;
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_b <= ({32'd0, 32'(ax_a * num_a)} << (OUT_FRAC_BITS + 1)) + {31'd0, d_a};
			ny_b <= ({32'd0, 32'(ay_a * num_a)} << (OUT_FRAC_BITS + 1)) + {31'd0, d_a};
			dv_b <= {30'd0, d_a, 1'b0};
			negx_b <= nx_a;
			negy_b <= ny_a;
			dead_b <= dead_a;
			zero_b <= zero_a;
		end
	end

	// divider: restoring, QW quotient bits, STEPS per stage, two lanes.
	// The quotient stays below 2^QW, so the dividend bits above QW are already
	// smaller than the divisor and seed the remainder; only the low QW bits shift in.
	logic [NW-1:0] rx [DS+1], ry [DS+1], dd [DS+1];
	logic [QW-1:0] qx [DS+1], qy [DS+1], sx [DS+1], sy [DS+1];
	logic [DS:0] ngx, ngy, dk, zk;
	always_comb begin
		rx[0] = {{QW{1'b0}}, nx_b[NW-1:QW]}; ry[0] = {{QW{1'b0}}, ny_b[NW-1:QW]};
		dd[0] = dv_b;
		sx[0] = nx_b[QW-1:0]; sy[0] = ny_b[QW-1:0];
		qx[0] = '0; qy[0] = '0;
		ngx[0] = negx_b; ngy[0] = negy_b; dk[0] = dead_b; zk[0] = zero_b;
	end
	generate
		for (g = 0; g < DS; g++) begin : g_dv
			logic [NW-1:0] rxn, ryn;
			logic [QW-1:0] qxn, qyn, sxn, syn;
			always_comb begin
				rxn = rx[g]; ryn = ry[g]; qxn = qx[g]; qyn = qy[g];
				sxn = sx[g]; syn = sy[g];
				for (int k = 0; k < STEPS; k++) begin
					rxn = {rxn[NW-2:0], sxn[QW-1]};
					ryn = {ryn[NW-2:0], syn[QW-1]};
					sxn = {sxn[QW-2:0], 1'b0};
					syn = {syn[QW-2:0], 1'b0};
					if (rxn >= dd[g]) begin rxn = rxn - dd[g]; qxn = {qxn[QW-2:0], 1'b1}; end
					else qxn = {qxn[QW-2:0], 1'b0};
					if (ryn >= dd[g]) begin ryn = ryn - dd[g]; qyn = {qyn[QW-2:0], 1'b1}; end
					else qyn = {qyn[QW-2:0], 1'b0};
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					rx[g+1] <= rxn; ry[g+1] <= ryn; qx[g+1] <= qxn; qy[g+1] <= qyn;
					sx[g+1] <= sxn; sy[g+1] <= syn; dd[g+1] <= dd[g];
					ngx[g+1] <= ngx[g]; ngy[g+1] <= ngy[g];
					dk[g+1] <= dk[g]; zk[g+1] <= zk[g];
				end
			end
		end
	endgenerate

	// output register with saturation
	function automatic logic signed [15:0] sat(input logic neg, input logic [QW-1:0] q);
		logic signed [15:0] r;
		if (neg) r = (q > 32'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, q}));
		else r = (q > 32'd32767) ? 16'sd32767 : 16'(q);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			out_res.dead <= dk[DS];
			out_res.sx <= (dk[DS] || zk[DS]) ? '0 : sat(ngx[DS], qx[DS]);
			out_res.sy <= (dk[DS] || zk[DS]) ? '0 : sat(ngy[DS], qy[DS]);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> q_ready) else $error("stall without result");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_res.dead) |-> (out_res.sx == 0 && out_res.sy == 0))
		else $error("dead zone nonzero");
endmodule
`default_nettype wire

>>> src/radial_stick_deadzone_scaler.sv
// From input accept to output valid, the accept edge writes the queue, then 28 back
// stages follow (square sum, 16 sqrt, 2 multiply, 8 divide, output register).
// Throughput one item per cycle, set by the fully pipelined sqrt and divider;
// an output stall freezes the whole back pipe.
// A two-entry queue parts the front from the back; each stalls on its own.
// Reset (arst_n, async, low) empties the queue and pipe and loads the dead zones
// with 7849 (left) and 8689 (right).
`default_nettype none
module radial_stick_deadzone_scaler #(
	parameter int OUT_FRAC_BITS = 15
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // axis_x[15:0], axis_y[31:16]
	input wire logic s_axis_tuser,        // stick_select
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [31:0] m_axis_tdata,     // scaled_x[15:0], scaled_y[31:16]
	output logic m_axis_tuser,            // in_dead_zone
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [14:0] cfg_data
);
	logic [14:0] left_dz_q, right_dz_q;
	logic q_valid, q_ready;
	rsds_pkg::rsds_item_t q_item;
	rsds_pkg::rsds_res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q <= 15'd7849;
			right_dz_q <= 15'd8689;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsds_pkg::REG_LEFT_DZ: left_dz_q <= cfg_data;
				rsds_pkg::REG_RIGHT_DZ: right_dz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rsds_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_x(s_axis_tdata[15:0]), .in_y(s_axis_tdata[31:16]), .in_sel(s_axis_tuser),
		.left_dz(left_dz_q), .right_dz(right_dz_q),
		.q_valid, .q_ready, .q_item
	);

	rsds_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = {res.sy, res.sx};
	assign m_axis_tuser = res.dead;
endmodule
`default_nettype wire

>>> tb/sv/tb_radial_stick_deadzone_scaler.sv
// Testbench for radial_stick_deadzone_scaler: directed and random stick samples
// checked against an in-bench predictor of the dead-zone rescale.
// Depends on rsds_pkg and the RTL top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_radial_stick_deadzone_scaler;
	localparam int FRAC = 15;
	localparam int SETTLE = 60;
	localparam longint LIMIT = 2000000;
	localparam longint unsigned MAXM = 64'(rsds_pkg::MAX_MAG);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // axis_x[15:0], axis_y[31:16]
	logic s_axis_tuser = 1'b0;        // stick_select
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // scaled_x[15:0], scaled_y[31:16]
	logic m_axis_tuser;               // in_dead_zone
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = rsds_pkg::REG_LEFT_DZ;
	logic [14:0] cfg_data = '0;

	radial_stick_deadzone_scaler u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial forever #5 clk = ~clk;

	// predictor copy of the dead-zone registers
	logic [14:0] left_dz = 15'd7849;
	logic [14:0] right_dz = 15'd8689;

	rsds_pkg::rsds_res_t expected_q[$];
	int mismatches = 0;
	int sent = 0;
	int checked = 0;
	int dead_seen = 0;
	int send_idle_pct = 0;  // chance of a gap before each item
	int recv_stall_pct = 0; // chance of holding tready low each cycle
	longint cycles = 0;

	// floor square root by bit-at-a-time search
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		for (int i = 16; i >= 0; i--) begin
			b = r | (longint'(1) << i);
			if (b * b <= v)
				r = b;
		end
		return r;
	endfunction

	// one axis: round half away from zero, then saturate
	function automatic logic [15:0] scale_component(logic signed [15:0] c,
			longint unsigned num, longint unsigned d);
		longint unsigned a;
		longint unsigned n;
		longint unsigned q;
		a = (c < 0) ? longint'(-int'(c)) : longint'(c);
		n = a * num * (longint'(1) << FRAC);
		q = (2 * n + d) / (2 * d);
		if (c < 0)
			return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
		return (q > 32767) ? 16'h7fff : 16'(q);
	endfunction

	function automatic rsds_pkg::rsds_res_t deadzone_rescale(logic signed [15:0] x,
			logic signed [15:0] y, logic sel);
		rsds_pkg::rsds_res_t r;
		longint unsigned dz, ax, ay, mag, m;
		dz = 64'(sel ? left_dz : right_dz);
		ax = (x < 0) ? longint'(-int'(x)) : longint'(x);
		ay = (y < 0) ? longint'(-int'(y)) : longint'(y);
		mag = root_floor(ax * ax + ay * ay);
		r = '0;
		if (mag <= dz) begin
			r.dead = 1'b1;
			return r;
		end
		m = (mag > MAXM) ? MAXM : mag;
		// dz is at most 32767, so den is zero only at that register value
		if (MAXM == dz || m == dz)
			return r;
		r.sx = scale_component(x, m - dz, mag * (MAXM - dz));
		r.sy = scale_component(y, m - dz, mag * (MAXM - dz));
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("ERROR item %0d %s: got %0d expected %0d", checked, what, got, want);
	endtask

	// result side: random stalls, compare at each accepted item
	always @(posedge clk) begin
		rsds_pkg::rsds_res_t want;
		cycles <= cycles + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if ($signed(m_axis_tdata[15:0]) !== want.sx)
					report_mismatch("scaled_x", int'($signed(m_axis_tdata[15:0])),
						int'(want.sx));
				if ($signed(m_axis_tdata[31:16]) !== want.sy)
					report_mismatch("scaled_y", int'($signed(m_axis_tdata[31:16])),
						int'(want.sy));
				if (m_axis_tuser !== want.dead)
					report_mismatch("in_dead_zone", int'(m_axis_tuser), int'(want.dead));
				if (want.dead)
					dead_seen++;
			end
			checked++;
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk)
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end

	// send one stick sample and hold it until accepted; tvalid is dropped
	// only for idle gaps or by drain, so back-to-back items need no gap
	task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y, logic sel);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {y, x};
		s_axis_tuser <= sel;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_q = {expected_q, deadzone_rescale(x, y, sel)};
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// idle-only register write; predictor follows at once
	task automatic write_dead_zone(logic [0:0] idx, logic [14:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rsds_pkg::REG_LEFT_DZ)
			left_dz = val;
		else
			right_dz = val;
	endtask

	task automatic test_directed();
		// origin, both corners, axes extremes, edge of the dead zone
		send_sample(16'sd0, 16'sd0, 1'b1);
		send_sample(16'sd0, 16'sd0, 1'b0);
		send_sample(16'sh8000, 16'sh8000, 1'b1);
		send_sample(16'sd32767, 16'sd32767, 1'b0);
		send_sample(16'sd32767, 16'sd0, 1'b1);        // full deflection
		send_sample(16'sh8000, 16'sd0, 1'b0);
		send_sample(16'sd0, 16'sh8000, 1'b1);
		send_sample(16'sd0, 16'sd32767, 1'b0);
		send_sample(16'sd7849, 16'sd0, 1'b1);         // exactly at left dead zone
		send_sample(16'sd7850, 16'sd0, 1'b1);
		send_sample(16'sd0, -16'sd8689, 1'b0);
		send_sample(16'sd0, -16'sd8690, 1'b0);
		send_sample(16'sh8000, 16'sd32767, 1'b1);
		send_sample(-16'sd1, 16'sd1, 1'b0);
		send_sample(16'sd23170, -16'sd23170, 1'b1);
		send_sample(-16'sd5000, 16'sd6000, 1'b0);
	endtask

	task automatic test_random(int count);
		logic signed [15:0] x, y;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(3);
			if (r == 0) begin
				// samples near the dead-zone edge
				x = 16'(int'($urandom_range(12000)) - 6000);
				y = 16'(int'($urandom_range(12000)) - 6000);
			end else if (r == 1) begin
				x = 16'(int'($urandom_range(600)) - 300);
				y = 16'(int'($urandom_range(600)) - 300);
			end else begin
				x = 16'($urandom);
				y = 16'($urandom);
			end
			send_sample(x, y, 1'($urandom_range(1)));
		end
	endtask

	task automatic test_settings();
		// extremes and random dead zones, random traffic under each
		write_dead_zone(rsds_pkg::REG_LEFT_DZ, 15'd0);
		write_dead_zone(rsds_pkg::REG_RIGHT_DZ, 15'd32766);
		send_sample(16'sd32767, 16'sd0, 1'b0);
		send_sample(16'sh8000, 16'sh8000, 1'b0);
		send_sample(16'sd1, 16'sd0, 1'b1);
		test_random(100);
		write_dead_zone(rsds_pkg::REG_LEFT_DZ, 15'd32767); // equals MAX_MAG: zero outside
		write_dead_zone(rsds_pkg::REG_RIGHT_DZ, 15'd0);
		send_sample(16'sh8000, 16'sh8000, 1'b1);
		test_random(100);
		write_dead_zone(rsds_pkg::REG_LEFT_DZ, 15'($urandom));
		write_dead_zone(rsds_pkg::REG_RIGHT_DZ, 15'($urandom_range(4000)));
		test_random(100);
	endtask

	task automatic test_idling();
		send_idle_pct = 0;   recv_stall_pct = 0;  test_random(250);
		send_idle_pct = 77;  recv_stall_pct = 0;  test_random(250);
		send_idle_pct = 0;   recv_stall_pct = 77; test_random(250);
		send_idle_pct = 11;  recv_stall_pct = 11; test_random(250);
		send_idle_pct = 0;   recv_stall_pct = 0;
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_idling();
		test_settings();
		drain();
		$display("Sent %0d samples, checked %0d results (%0d in dead zone).",
			sent, checked, dead_seen);
		$display("Dead-zone extremes and stall phases on both sides were exercised.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
src/rsds_pkg.sv
src/rsds_front.sv
src/rsds_back.sv
src/radial_stick_deadzone_scaler.sv
tb/sv/tb_radial_stick_deadzone_scaler.sv
